// ===== rtl/sstk_pkg.sv =====
// Package for the protective stop tracker: sizes, register codes, sequencer states,
// and the structs between the sequencer, the divider and the ratchet.
// Depends on nothing; every other file of the block but sstk_ram uses it.
package sstk_pkg;

  localparam int MAX_LOOKBACK = 64;
  localparam int MAX_HOLD     = 16;
  localparam int PRICE_BITS   = 32;

  localparam int HIST_DEPTH = MAX_LOOKBACK + 1;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int BAR_W      = 2 * PRICE_BITS;
  localparam int CNT_W      = $clog2(MAX_LOOKBACK + 1);
  localparam int RD_W       = $clog2(MAX_LOOKBACK + 2);
  localparam int SUM_W      = PRICE_BITS + $clog2(MAX_LOOKBACK);
  localparam int DIV_CW     = $clog2(SUM_W + 1);
  localparam int HOLD_IW    = $clog2(MAX_HOLD);
  localparam int HOLD_CW    = $clog2(MAX_HOLD + 1);

  localparam int LB_W      = 7;
  localparam int HB_W      = 5;
  localparam int GAIN_W    = 16;
  localparam int FRAC_BITS = 8;
  localparam int PROD_W    = GAIN_W + PRICE_BITS;
  localparam int OFF_W     = PROD_W - FRAC_BITS;
  localparam int STOP_W    = 48;
  localparam int EXT_W     = STOP_W + 2;

  localparam int IDX_W   = 11;
  localparam int IDX_MAX = 2047;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LOOKBACK = CFG_IDX_W'(0);
  localparam cfg_idx_t CFG_HOLD     = CFG_IDX_W'(1);
  localparam cfg_idx_t CFG_GAIN     = CFG_IDX_W'(2);

  localparam logic [LB_W-1:0]   RST_LOOKBACK = LB_W'(10);
  localparam logic [HB_W-1:0]   RST_HOLD     = HB_W'(2);
  localparam logic [GAIN_W-1:0] RST_GAIN     = GAIN_W'(640);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DN_GO,
    ST_DN_WAIT,
    ST_UP_GO,
    ST_UP_WAIT,
    ST_MUL_DN,
    ST_MUL_UP,
    ST_ADD_UP,
    ST_RAT_GO,
    ST_RAT_WAIT,
    ST_OUT,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [PRICE_BITS-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                     start;
    logic [HB_W-1:0]          hold;
    logic signed [STOP_W-1:0] long_raw;
    logic signed [STOP_W-1:0] short_raw;
  } rat_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [STOP_W-1:0] long_adj;
    logic signed [STOP_W-1:0] short_adj;
  } rat_rsp_t;

  // Clamps a widened stop value into the signed output range.
  function automatic logic signed [STOP_W-1:0] sat_stop(input logic signed [EXT_W-1:0] v);
    logic signed [STOP_W-1:0] r;
    if (v[EXT_W-1:STOP_W-1] == '0 || v[EXT_W-1:STOP_W-1] == '1) begin
      r = v[STOP_W-1:0];
    end else if (v[EXT_W-1]) begin
      r = {1'b1, {(STOP_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(STOP_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/sstk_if.sv =====
// Channel interfaces of the stop tracker: bar input, stop output, register writes.
// Depends on sstk_pkg for the field widths.
interface sstk_bar_if;
  logic                            valid;
  logic                            ready;
  logic [sstk_pkg::PRICE_BITS-1:0] bar_high;
  logic [sstk_pkg::PRICE_BITS-1:0] bar_low;
  modport source (output valid, bar_high, bar_low, input ready);
  modport sink (input valid, bar_high, bar_low, output ready);
endinterface

interface sstk_stop_if;
  logic                               valid;
  logic                               ready;
  logic signed [sstk_pkg::STOP_W-1:0] long_stop;
  logic signed [sstk_pkg::STOP_W-1:0] short_stop;
  modport source (output valid, long_stop, short_stop, input ready);
  modport sink (input valid, long_stop, short_stop, output ready);
endinterface

interface sstk_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sstk_pkg::CFG_IDX_W-1:0]  index;
  logic [sstk_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/sstk_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sstk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sstk_div.sv =====
// Restoring serial divider, one quotient bit per cycle, for the window averages.
// Depends on sstk_pkg for widths and the request and response structs.
module sstk_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sstk_pkg::div_req_t req_i,
  output sstk_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [sstk_pkg::DIV_CW-1:0]   cnt_q, cnt_d;
  logic [sstk_pkg::SUM_W-1:0]    num_q, num_d;
  logic [sstk_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [sstk_pkg::CNT_W-1:0]    den_q, den_d;
  logic [sstk_pkg::CNT_W:0]      rem_sh;
  logic [sstk_pkg::CNT_W:0]      rem_sub;
  logic                          ge;

  always_comb begin
    rem_sh  = {rem_q, num_q[sstk_pkg::SUM_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (busy_q) begin
      num_d = {num_q[sstk_pkg::SUM_W-2:0], ge};
      rem_d = ge ? rem_sub[sstk_pkg::CNT_W-1:0] : rem_sh[sstk_pkg::CNT_W-1:0];
      cnt_d = cnt_q - sstk_pkg::DIV_CW'(1);
      if (cnt_q == sstk_pkg::DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = sstk_pkg::DIV_CW'(sstk_pkg::SUM_W);
      num_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = num_q[sstk_pkg::PRICE_BITS-1:0];

endmodule

// ===== rtl/sstk_ratchet.sv =====
// Stop history and ratchet: scans earlier raw stops one per cycle with a shared
// compare pair, then pushes the new raw stops. Depends on sstk_pkg.
module sstk_ratchet (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sstk_pkg::rat_req_t req_i,
  output sstk_pkg::rat_rsp_t rsp_o
);

  logic signed [sstk_pkg::STOP_W-1:0] long_hist_q  [sstk_pkg::MAX_HOLD];
  logic signed [sstk_pkg::STOP_W-1:0] short_hist_q [sstk_pkg::MAX_HOLD];
  logic signed [sstk_pkg::STOP_W-1:0] long_adj_q, short_adj_q;
  logic signed [sstk_pkg::STOP_W-1:0] long_raw_q, short_raw_q;
  logic [sstk_pkg::HOLD_CW-1:0]       made_q, left_q, hold_c, span;
  logic [sstk_pkg::HOLD_IW-1:0]       idx_q;
  logic                               busy_q, done_q;
  logic                               do_start, do_scan, do_push;

  always_comb begin
    if (int'(req_i.hold) > sstk_pkg::MAX_HOLD) begin
      hold_c = sstk_pkg::HOLD_CW'(sstk_pkg::MAX_HOLD);
    end else begin
      hold_c = sstk_pkg::HOLD_CW'(req_i.hold);
    end
    span     = (hold_c > made_q) ? made_q : hold_c;
    do_start = req_i.start && !busy_q;
    do_scan  = busy_q && (left_q != '0);
    do_push  = busy_q && (left_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      made_q <= '0;
      left_q <= '0;
      idx_q  <= '0;
    end else begin
      done_q <= do_push;
      if (do_start) begin
        busy_q <= 1'b1;
        left_q <= span;
        idx_q  <= '0;
      end else if (do_scan) begin
        left_q <= left_q - sstk_pkg::HOLD_CW'(1);
        idx_q  <= idx_q + sstk_pkg::HOLD_IW'(1);
      end else if (do_push) begin
        busy_q <= 1'b0;
        if (int'(made_q) < sstk_pkg::MAX_HOLD) begin
          made_q <= made_q + sstk_pkg::HOLD_CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_start) begin
      long_raw_q  <= req_i.long_raw;
      short_raw_q <= req_i.short_raw;
      long_adj_q  <= req_i.long_raw;
      short_adj_q <= req_i.short_raw;
    end else if (do_scan) begin
      if (long_hist_q[idx_q] > long_adj_q) begin
        long_adj_q <= long_hist_q[idx_q];
      end
      if (short_hist_q[idx_q] < short_adj_q) begin
        short_adj_q <= short_hist_q[idx_q];
      end
    end
    if (do_push) begin
      for (int i = sstk_pkg::MAX_HOLD - 1; i > 0; i--) begin
        long_hist_q[i]  <= long_hist_q[i-1];
        short_hist_q[i] <= short_hist_q[i-1];
      end
      long_hist_q[0]  <= long_raw_q;
      short_hist_q[0] <= short_raw_q;
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.long_adj  = long_adj_q;
  assign rsp_o.short_adj = short_adj_q;

endmodule

// ===== rtl/safezone_stop_tracker_top.sv =====
// Top level of the protective stop tracker: sequencer, bar history RAM, window
// accumulators and the stop arithmetic. Depends on sstk_pkg, the channel
// interfaces, sstk_ram, sstk_div and sstk_ratchet.
//
// The bar channel takes one word per price bar (high, low); the stop channel
// gives one word (long stop, short stop) for each bar whose index is above the
// lookback (1 if zero, 64 at most), and nothing for earlier bars. The config
// channel is always ready and should only be written while no bar is in
// progress. The block takes one bar at a time and drops ready until that bar
// is done. A bar that makes no result is only written to the history RAM. A
// bar that makes a result reads pairs + 1 earlier bars, where pairs is the
// number of bar pairs in the window (at most the lookback), and checks hold
// earlier stops, where hold is limited to the stops made so far: the history
// RAM is read one bar a cycle, the divider gives one quotient bit a cycle for
// each of the two averages, and the ratchet checks one earlier stop a cycle.
// The finished word sits in an output register, so the next bar is taken
// while it waits; if the receiver stalls longer than one bar takes, the
// sequencer holds before writing the next word. Reset clears the bar count,
// the stop count and the registers to their defaults; the bar history needs
// no clearing, since only bars already written are read.
module safezone_stop_tracker_top (
  input logic          clk_i,
  input logic          rst_ni,
  sstk_bar_if.sink     bar_i,
  sstk_stop_if.source  stop_o,
  sstk_cfg_if.sink     cfg_i
);

  localparam int P = sstk_pkg::PRICE_BITS;

  sstk_pkg::state_e state_q, state_d;

  logic [sstk_pkg::LB_W-1:0]          lookback_q;
  logic [sstk_pkg::HB_W-1:0]          hold_q;
  logic [sstk_pkg::GAIN_W-1:0]        gain_q;

  logic [P-1:0]                       hi_q, lo_q;
  logic [P-1:0]                       prev_hi_q, prev_lo_q, last_hi_q, last_lo_q;
  logic [sstk_pkg::SUM_W-1:0]         dn_sum_q, up_sum_q;
  logic [sstk_pkg::CNT_W-1:0]         dn_cnt_q, up_cnt_q;
  logic [P-1:0]                       dn_avg_q, up_avg_q;
  logic [sstk_pkg::PROD_W-1:0]        prod_q;
  logic signed [sstk_pkg::STOP_W-1:0] long_raw_q, short_raw_q;
  logic [sstk_pkg::RD_W-1:0]          left_q;
  logic [sstk_pkg::HIST_AW-1:0]       rd_ptr_q, wr_ptr_q;
  logic                               rvalid_q, first_q;
  logic [sstk_pkg::IDX_W-1:0]         bar_idx_q;
  logic                               out_valid_q;
  logic signed [sstk_pkg::STOP_W-1:0] out_long_q, out_short_q;

  logic                               bar_ready, bar_acc, has_result;
  logic                               ram_re, ram_we, out_free, out_load;
  logic [sstk_pkg::CNT_W-1:0]         lb_eff, pairs;
  logic [sstk_pkg::IDX_W-1:0]         n_m2;
  logic [sstk_pkg::HIST_AW-1:0]       rd_start, rd_next, wr_next;
  logic [sstk_pkg::BAR_W-1:0]         ram_rdata;
  logic [P-1:0]                       rd_hi, rd_lo;
  logic [sstk_pkg::OFF_W-1:0]         offset;
  logic [P-1:0]                       mul_in;
  logic signed [sstk_pkg::EXT_W-1:0]  long_ext, short_ext;

  sstk_pkg::div_req_t div_req;
  sstk_pkg::div_rsp_t div_rsp;
  sstk_pkg::rat_req_t rat_req;
  sstk_pkg::rat_rsp_t rat_rsp;

  // Window size, pair count, history pointers and stop arithmetic for the bar.
  always_comb begin
    if (lookback_q == '0) begin
      lb_eff = sstk_pkg::CNT_W'(1);
    end else if (int'(lookback_q) > sstk_pkg::MAX_LOOKBACK) begin
      lb_eff = sstk_pkg::CNT_W'(sstk_pkg::MAX_LOOKBACK);
    end else begin
      lb_eff = sstk_pkg::CNT_W'(lookback_q);
    end
    has_result = bar_idx_q > sstk_pkg::IDX_W'(lb_eff);
    n_m2       = bar_idx_q - sstk_pkg::IDX_W'(2);
    pairs      = (n_m2 < sstk_pkg::IDX_W'(lb_eff)) ? sstk_pkg::CNT_W'(n_m2) : lb_eff;
    rd_start   = (wr_ptr_q == '0) ? sstk_pkg::HIST_AW'(sstk_pkg::HIST_DEPTH - 1)
                                  : wr_ptr_q - sstk_pkg::HIST_AW'(1);
    rd_next    = (rd_ptr_q == '0) ? sstk_pkg::HIST_AW'(sstk_pkg::HIST_DEPTH - 1)
                                  : rd_ptr_q - sstk_pkg::HIST_AW'(1);
    wr_next    = (wr_ptr_q == sstk_pkg::HIST_AW'(sstk_pkg::HIST_DEPTH - 1)) ? '0
                                  : wr_ptr_q + sstk_pkg::HIST_AW'(1);
    rd_hi      = ram_rdata[sstk_pkg::BAR_W-1:P];
    rd_lo      = ram_rdata[P-1:0];
    offset     = prod_q[sstk_pkg::PROD_W-1:sstk_pkg::FRAC_BITS];
    mul_in     = (state_q == sstk_pkg::ST_MUL_DN) ? dn_avg_q : up_avg_q;
    long_ext   = $signed(sstk_pkg::EXT_W'(prev_lo_q)) - $signed(sstk_pkg::EXT_W'(offset));
    short_ext  = $signed(sstk_pkg::EXT_W'(prev_hi_q)) + $signed(sstk_pkg::EXT_W'(offset));
    out_free   = !out_valid_q || stop_o.ready;
  end

  // Sequencer outputs.
  always_comb begin
    bar_ready     = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    div_req.start = 1'b0;
    rat_req.start = 1'b0;
    unique case (state_q)
      sstk_pkg::ST_IDLE:  bar_ready = 1'b1;
      sstk_pkg::ST_READ:  ram_re = (left_q != '0);
      sstk_pkg::ST_DN_GO,
      sstk_pkg::ST_UP_GO: div_req.start = 1'b1;
      sstk_pkg::ST_RAT_GO: rat_req.start = 1'b1;
      sstk_pkg::ST_OUT: begin
        out_load = out_free;
        ram_we   = out_free;
      end
      sstk_pkg::ST_WRITE: ram_we = 1'b1;
      default: ;
    endcase
    bar_acc          = bar_i.valid && bar_ready;
    div_req.dividend = (state_q == sstk_pkg::ST_DN_GO) ? dn_sum_q : up_sum_q;
    div_req.divisor  = (state_q == sstk_pkg::ST_DN_GO) ? dn_cnt_q : up_cnt_q;
    rat_req.hold      = hold_q;
    rat_req.long_raw  = long_raw_q;
    rat_req.short_raw = short_raw_q;
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sstk_pkg::ST_IDLE: begin
        if (bar_acc) begin
          state_d = has_result ? sstk_pkg::ST_READ : sstk_pkg::ST_WRITE;
        end
      end
      sstk_pkg::ST_READ: begin
        if (left_q == '0 && !rvalid_q) begin
          state_d = sstk_pkg::ST_DN_GO;
        end
      end
      sstk_pkg::ST_DN_GO: state_d = sstk_pkg::ST_DN_WAIT;
      sstk_pkg::ST_DN_WAIT: begin
        if (div_rsp.done) begin
          state_d = sstk_pkg::ST_UP_GO;
        end
      end
      sstk_pkg::ST_UP_GO: state_d = sstk_pkg::ST_UP_WAIT;
      sstk_pkg::ST_UP_WAIT: begin
        if (div_rsp.done) begin
          state_d = sstk_pkg::ST_MUL_DN;
        end
      end
      sstk_pkg::ST_MUL_DN: state_d = sstk_pkg::ST_MUL_UP;
      sstk_pkg::ST_MUL_UP: state_d = sstk_pkg::ST_ADD_UP;
      sstk_pkg::ST_ADD_UP: state_d = sstk_pkg::ST_RAT_GO;
      sstk_pkg::ST_RAT_GO: state_d = sstk_pkg::ST_RAT_WAIT;
      sstk_pkg::ST_RAT_WAIT: begin
        if (rat_rsp.done) begin
          state_d = sstk_pkg::ST_OUT;
        end
      end
      sstk_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = sstk_pkg::ST_IDLE;
        end
      end
      sstk_pkg::ST_WRITE: state_d = sstk_pkg::ST_IDLE;
      default: state_d = sstk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sstk_pkg::ST_IDLE;
      lookback_q  <= sstk_pkg::RST_LOOKBACK;
      hold_q      <= sstk_pkg::RST_HOLD;
      gain_q      <= sstk_pkg::RST_GAIN;
      left_q      <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      rvalid_q    <= 1'b0;
      first_q     <= 1'b0;
      bar_idx_q   <= '0;
      out_valid_q <= 1'b0;
      dn_cnt_q    <= '0;
      up_cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= ram_re;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          sstk_pkg::CFG_LOOKBACK: lookback_q <= cfg_i.data[sstk_pkg::LB_W-1:0];
          sstk_pkg::CFG_HOLD:     hold_q     <= cfg_i.data[sstk_pkg::HB_W-1:0];
          sstk_pkg::CFG_GAIN:     gain_q     <= cfg_i.data[sstk_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (bar_acc) begin
        left_q   <= has_result ? sstk_pkg::RD_W'(pairs) + sstk_pkg::RD_W'(1) : '0;
        rd_ptr_q <= rd_start;
        first_q  <= 1'b1;
        dn_cnt_q <= '0;
        up_cnt_q <= '0;
      end
      if (ram_re) begin
        left_q   <= left_q - sstk_pkg::RD_W'(1);
        rd_ptr_q <= rd_next;
      end
      if (rvalid_q) begin
        first_q <= 1'b0;
        if (!first_q && last_lo_q < rd_lo) begin
          dn_cnt_q <= dn_cnt_q + sstk_pkg::CNT_W'(1);
        end
        if (!first_q && last_hi_q > rd_hi) begin
          up_cnt_q <= up_cnt_q + sstk_pkg::CNT_W'(1);
        end
      end
      if (ram_we) begin
        wr_ptr_q <= wr_next;
        if (int'(bar_idx_q) < sstk_pkg::IDX_MAX) begin
          bar_idx_q <= bar_idx_q + sstk_pkg::IDX_W'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (stop_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bar_acc) begin
      hi_q     <= bar_i.bar_high;
      lo_q     <= bar_i.bar_low;
      dn_sum_q <= '0;
      up_sum_q <= '0;
    end
    if (rvalid_q) begin
      last_hi_q <= rd_hi;
      last_lo_q <= rd_lo;
      if (first_q) begin
        prev_hi_q <= rd_hi;
        prev_lo_q <= rd_lo;
      end else begin
        if (last_lo_q < rd_lo) begin
          dn_sum_q <= dn_sum_q + sstk_pkg::SUM_W'(rd_lo - last_lo_q);
        end
        if (last_hi_q > rd_hi) begin
          up_sum_q <= up_sum_q + sstk_pkg::SUM_W'(last_hi_q - rd_hi);
        end
      end
    end
    if (state_q == sstk_pkg::ST_DN_WAIT && div_rsp.done) begin
      dn_avg_q <= (dn_cnt_q == '0) ? '0 : div_rsp.quotient;
    end
    if (state_q == sstk_pkg::ST_UP_WAIT && div_rsp.done) begin
      up_avg_q <= (up_cnt_q == '0) ? '0 : div_rsp.quotient;
    end
    if (state_q == sstk_pkg::ST_MUL_DN || state_q == sstk_pkg::ST_MUL_UP) begin
      prod_q <= sstk_pkg::PROD_W'(gain_q) * sstk_pkg::PROD_W'(mul_in);
    end
    if (state_q == sstk_pkg::ST_MUL_UP) begin
      long_raw_q <= sstk_pkg::sat_stop(long_ext);
    end
    if (state_q == sstk_pkg::ST_ADD_UP) begin
      short_raw_q <= sstk_pkg::sat_stop(short_ext);
    end
    if (out_load) begin
      out_long_q  <= rat_rsp.long_adj;
      out_short_q <= rat_rsp.short_adj;
    end
  end

  sstk_ram #(
    .WIDTH (sstk_pkg::BAR_W),
    .DEPTH (sstk_pkg::HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i ({hi_q, lo_q}),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  sstk_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sstk_ratchet u_ratchet (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rat_req),
    .rsp_o  (rat_rsp)
  );

  assign bar_i.ready       = bar_ready;
  assign cfg_i.ready       = 1'b1;
  assign stop_o.valid      = out_valid_q;
  assign stop_o.long_stop  = out_long_q;
  assign stop_o.short_stop = out_short_q;

`ifndef SYNTH
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bar_i.valid && bar_i.ready) |=> !bar_i.ready)
    else $error("bar word accepted while the previous bar is in progress");

  a_write_after_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (!rvalid_q && !ram_re && left_q == '0))
    else $error("history write overlaps the window reads");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_idx_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> bar_idx_q >= $past(bar_idx_q))
    else $error("bar count went backward");
`endif

endmodule
